[hw/rtl/hff_pkg.sv]
// shared types and character constants of the hex field formatter
package hff_pkg;

    localparam int CNT_W = 7;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_X_UP  = 8'h58;
    localparam logic [7:0] CHAR_X_LO  = 8'h78;
    localparam logic [7:0] CHAR_A_UP  = 8'h41;
    localparam logic [7:0] CHAR_A_LO  = 8'h61;
    localparam logic [3:0] DEC_LIMIT  = 4'd10;

    // one classified field, ready for the emitter
    typedef struct packed {
        logic [31:0]      value;
        logic             upper;
        logic             prefix;
        logic [CNT_W-1:0] prefix_pos;
        logic [CNT_W-1:0] body_start;
        logic [CNT_W-1:0] digit_end;
        logic [CNT_W-1:0] count;
    } hff_desc_t;

    typedef struct packed {
        logic      valid;
        hff_desc_t desc;
    } hff_push_t;

    typedef struct packed {
        logic      valid;
        hff_desc_t desc;
    } hff_head_t;

endpackage

[hw/rtl/hff_in_if.sv]
// input channel: one value and its conversion flags
interface hff_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        upper_case;
    logic        alt_form;
    logic        left_align;
    logic        zero_pad;
    logic        precision_given;
    logic [5:0]  precision;
    logic [6:0]  field_width;

    modport source (
        output valid, value, upper_case, alt_form, left_align, zero_pad,
               precision_given, precision, field_width,
        input  ready
    );
    modport sink (
        input  valid, value, upper_case, alt_form, left_align, zero_pad,
               precision_given, precision, field_width,
        output ready
    );
endinterface

[hw/rtl/hff_out_if.sv]
// output channel: one character of the formatted field
interface hff_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;
    logic [6:0] field_length;

    modport source (
        output valid, ch, last, field_length,
        input  ready
    );
    modport sink (
        input  valid, ch, last, field_length,
        output ready
    );
endinterface

[hw/rtl/hff_front.sv]
// front end: accepts a value and works out the layout of its field
module hff_front #(
    parameter int MAX_FIELD = 64
) (
    hff_in_if.sink          fmt_in,
    input  logic            q_full,
    output hff_pkg::hff_push_t push
);
    import hff_pkg::*;

    localparam int CAP = (MAX_FIELD > 127) ? 127 : MAX_FIELD;

    logic [3:0]       nd;
    logic             is_zero;
    logic [CNT_W-1:0] digits;
    logic             pfx;
    logic [CNT_W-1:0] body_len;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] pad;
    logic             zmode;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] ppos;

    assign fmt_in.ready = !q_full;

    always_comb
    begin
        // significant hex digits, at least one
        nd = 4'd1;
        for (int k = 1; k < 8; k++)
        begin
            if (fmt_in.value[4*k +: 4] != 4'd0)
                nd = 4'(k + 1);
        end
        is_zero = (fmt_in.value == 32'd0);
        digits = ({3'b000, nd} < {1'b0, fmt_in.precision}) ?
                 {1'b0, fmt_in.precision} : {3'b000, nd};
        if (is_zero && fmt_in.precision_given && fmt_in.precision == 6'd0)
            digits = '0;
        pfx = fmt_in.alt_form && !is_zero;
        body_len = digits + (pfx ? 7'd2 : 7'd0);
        total = (fmt_in.field_width < body_len) ? body_len : fmt_in.field_width;
        pad = total - body_len;
        zmode = fmt_in.zero_pad && !fmt_in.left_align && !fmt_in.precision_given;
        n = (total < 7'(CAP)) ? total : 7'(CAP);
        ppos = (fmt_in.left_align || zmode) ? 7'd0 : pad;

        push.desc.value      = fmt_in.value;
        push.desc.upper      = fmt_in.upper_case;
        push.desc.prefix     = pfx;
        push.desc.prefix_pos = ppos;
        push.desc.body_start = ppos + (pfx ? 7'd2 : 7'd0);
        push.desc.digit_end  = fmt_in.left_align ? body_len : total;
        push.desc.count      = n;
        // an empty field produces nothing downstream
        push.valid = fmt_in.valid && !q_full && (n != 7'd0);
    end

endmodule

[hw/rtl/hff_queue.sv]
// two-entry descriptor queue between front end and emitter
module hff_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  hff_pkg::hff_push_t push,
    input  logic               pop,
    output logic               full,
    output hff_pkg::hff_head_t head
);
    import hff_pkg::*;

    hff_desc_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.desc  = entry_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.desc;
    end

endmodule

[hw/rtl/hff_back.sv]
// emitter: walks a field one character per cycle, while the output is not stalled, into the output register
module hff_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hff_pkg::hff_head_t head,
    output logic               pop,
    hff_out_if.source          fmt_out
);
    import hff_pkg::*;

    hff_desc_t        cur_reg, cur_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       ch_reg;
    logic             last_reg;
    logic [CNT_W-1:0] len_reg;

    logic             advance, finish, load;
    logic [CNT_W-1:0] idx;
    logic [3:0]       nib;
    logic [7:0]       digit_ch;
    logic [7:0]       ch_next;

    assign advance = cur_valid_reg && (!out_valid_reg || fmt_out.ready);
    assign finish  = advance && (pos_reg == cur_reg.count - 7'd1);
    assign load    = head.valid && (!cur_valid_reg || finish);
    assign pop     = load;

    always_comb
    begin
        // digit position counted from the least significant end
        idx = cur_reg.digit_end - 7'd1 - pos_reg;
        nib = (idx < 7'd8) ? cur_reg.value[{idx[2:0], 2'b00} +: 4] : 4'd0;
        if (nib < DEC_LIMIT)
            digit_ch = CHAR_ZERO + {4'd0, nib};
        else
            digit_ch = (cur_reg.upper ? CHAR_A_UP : CHAR_A_LO) + {4'd0, nib - DEC_LIMIT};

        priority if (cur_reg.prefix && pos_reg == cur_reg.prefix_pos)
            ch_next = CHAR_ZERO;
        else if (cur_reg.prefix && pos_reg == cur_reg.prefix_pos + 7'd1)
            ch_next = cur_reg.upper ? CHAR_X_UP : CHAR_X_LO;
        else if (pos_reg >= cur_reg.body_start && pos_reg < cur_reg.digit_end)
            ch_next = digit_ch;
        else
            ch_next = CHAR_SPACE;
    end

    always_comb
    begin
        cur_next       = load ? head.desc : cur_reg;
        cur_valid_next = load ? 1'b1 : (finish ? 1'b0 : cur_valid_reg);
        pos_next       = load ? 7'd0 : (advance ? pos_reg + 7'd1 : pos_reg);
        out_valid_next = advance ? 1'b1 : (fmt_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (advance)
        begin
            ch_reg   <= ch_next;
            last_reg <= finish;
            len_reg  <= cur_reg.count;
        end
    end

    assign fmt_out.valid        = out_valid_reg;
    assign fmt_out.ch           = ch_reg;
    assign fmt_out.last         = last_reg;
    assign fmt_out.field_length = len_reg;

endmodule

[hw/rtl/hex_field_formatter.sv]
// top level of the printf-style hex field formatter
//
// fmt_in carries one 32-bit value with its %x / %X flags, precision and
// field width; a transfer happens on a clock edge with valid and ready high
// fmt_out carries the field back one ASCII character per transfer, left to
// right, with last on the final character and the field length on every one
// the first character reaches fmt_out through the descriptor queue, the
// emitter's current-field register and the output register
// throughput: one character per cycle while fmt_out is not stalled, so a
// field of n characters (up to MAX_FIELD) holds the emitter until its last
// character; the emitter sets the item rate, while the front end accepts a new value every
// cycle as long as the two-entry descriptor queue has room
// a field of zero characters (zero value, precision 0, width 0) produces no
// transfer on fmt_out
// reset empties the queue, the emitter and the output register; no state
// carries between fields
// a stall on fmt_out holds the current character; the emitter and then the
// queue fill up and fmt_in.ready drops only when the queue is full
module hex_field_formatter #(
    parameter int MAX_FIELD = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    hff_in_if.sink    fmt_in,
    hff_out_if.source fmt_out
);
    import hff_pkg::*;

    hff_push_t push;
    hff_head_t head;
    logic      q_full;
    logic      pop;

    // front end: classify and lay out the field
    hff_front #(
        .MAX_FIELD (MAX_FIELD)
    ) u_front (
        .fmt_in (fmt_in),
        .q_full (q_full),
        .push   (push)
    );

    // decouples classification from character emission
    hff_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // back end: one character per cycle, when fmt_out is not stalled, into the output register
    hff_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .fmt_out (fmt_out)
    );

endmodule

[hw/rtl/hff_checker.sv]
// port-level checks of the formatter output channel, bound to the top level
module hff_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] ch,
    input logic       last,
    input logic [6:0] field_length
);

    // a pending character stays offered until taken
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped without a transfer");

    // a stalled character does not change
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(ch) && $stable(last) && $stable(field_length))
        else $error("output payload changed while stalled");

    // inside a field the next character follows at once with the same length
    a_field_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            out_valid && field_length == $past(field_length))
        else $error("field interrupted or length changed mid-field");

    // a one-character field closes on its only character
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_length == 7'd1 |-> last)
        else $error("single-character field without last");

endmodule

bind hex_field_formatter hff_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (fmt_out.valid),
    .out_ready    (fmt_out.ready),
    .ch           (fmt_out.ch),
    .last         (fmt_out.last),
    .field_length (fmt_out.field_length)
);

[verif/hex_field_formatter_tb.sv]
// self-checking testbench for the hex field formatter: directed table, then random fields
module hex_field_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hff_pkg::*;

    localparam int FIELD_CAP    = 64;
    localparam int RANDOM_ITEMS = 200;

    // one value with its conversion flags, as it crosses fmt_in
    typedef struct packed {
        logic [31:0] value;
        logic        upper_case;
        logic        alt_form;
        logic        left_align;
        logic        zero_pad;
        logic        precision_given;
        logic [5:0]  precision;
        logic [6:0]  field_width;
    } fmt_req_t;

    // one character as it should appear on fmt_out
    typedef struct packed {
        logic [7:0]       ch;
        logic             last;
        logic [CNT_W-1:0] field_length;
    } fmt_char_t;

    // per-transfer note: use the typed-in text instead of the predictor
    typedef struct {
        bit    typed;
        string text;
    } fmt_note_t;

    typedef struct {
        fmt_req_t req;
        bit       typed;
        string    text;
    } fmt_case_t;

    logic clk;
    logic rst_n;

    hff_in_if  fmt_in ();
    hff_out_if fmt_out ();

    hex_field_formatter #(.MAX_FIELD(FIELD_CAP)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .fmt_in  (fmt_in),
        .fmt_out (fmt_out)
    );

    fmt_char_t field_chars [$];   // characters still owed by the block, oldest first
    fmt_note_t item_notes [$];    // one entry per value handed to the sender, in order
    int        errors = 0;

    // directed rows: value, upper, alt, left, zero, dot, precision, width
    // rows with typed = 1 carry the exact field; the rest go through the predictor
    fmt_case_t directed_cases [25] = '{
        // zero value, no flags: a single digit
        '{'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},   1'b1, "0"},
        // zero value with precision 0 given: nothing at all
        '{'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd0,  7'd0},   1'b1, ""},
        // same, but the width leaves a field of pure padding
        '{'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd0,  7'd5},   1'b1, "     "},
        // alt flag on zero: no prefix
        '{'{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},   1'b1, "0"},
        '{'{32'hffff_ffff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},   1'b1, "ffffffff"},
        '{'{32'hffff_ffff, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},   1'b1, "0XFFFFFFFF"},
        '{'{32'habcd_ef12, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},   1'b1, "0xabcdef12"},
        '{'{32'h0123_4567, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},   1'b1, "1234567"},
        '{'{32'h89ab_cdef, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0,  7'd0},   1'b1, "89ABCDEF"},
        '{'{32'h0000_001a, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0,  7'd6},   1'b1, "    1a"},
        '{'{32'h0000_001a, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0,  7'd6},   1'b1, "1a    "},
        '{'{32'h0000_001a, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0,  7'd6},   1'b1, "00001a"},
        // zero padding goes between the prefix and the digits
        '{'{32'h0000_001a, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 6'd0,  7'd6},   1'b1, "0X001A"},
        // zero padding dropped under left alignment
        '{'{32'h0000_001a, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 6'd0,  7'd6},   1'b1, "1a    "},
        // zero padding dropped when a precision is given
        '{'{32'h0000_001a, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 6'd3,  7'd6},   1'b1, "   01a"},
        '{'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0,  7'd3},   1'b1, "000"},
        // width below the body length has no effect
        '{'{32'h0000_0001, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 6'd0,  7'd2},   1'b1, "0x1"},
        '{'{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd1,  7'd0},   1'b1, "10"},
        '{'{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 6'd0,  7'd0},   1'b1, ""},
        // long digit strings, the prefix pushing the body to the cap
        '{'{32'h0000_001a, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd62, 7'd0},   1'b0, ""},
        '{'{32'h0000_001a, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 6'd62, 7'd0},   1'b0, ""},
        '{'{32'h0000_000f, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 6'd0,  7'd64},  1'b0, ""},
        '{'{32'h00c0_ffee, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0,  7'd64},  1'b0, ""},
        // fields longer than the cap are cut at the cap
        '{'{32'hdead_beef, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 6'd63, 7'd127}, 1'b0, ""},
        '{'{32'h0000_0007, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0,  7'd127}, 1'b0, ""}
    };

    // one hex digit of v; positions past the top nibble read as '0'
    function automatic logic [7:0] hex_char(logic [31:0] v, int unsigned idx, logic up);
        logic [3:0] nib;
        if (idx >= 8)
        begin
            return CHAR_ZERO;
        end
        nib = v[4*idx +: 4];
        if (nib < DEC_LIMIT)
        begin
            return CHAR_ZERO + 8'(nib);
        end
        return (up ? CHAR_A_UP : CHAR_A_LO) + 8'(nib - DEC_LIMIT);
    endfunction

    // works out the whole field for one transfer and queues its characters
    function automatic void predict_field(fmt_req_t r);
        int unsigned ndig, dig, pre, body, total, pad, emit, j;
        logic        zmode;
        logic [7:0]  c;
        // significant digits, at least one even for zero
        ndig = 1;
        while (ndig < 8 && (r.value >> (4 * ndig)) != 0)
        begin
            ndig++;
        end
        dig = (ndig < r.precision) ? r.precision : ndig;
        // explicit precision 0 on a zero value prints no digit
        if (r.value == 0 && r.precision_given && r.precision == 0)
        begin
            dig = 0;
        end
        pre   = (r.alt_form && r.value != 0) ? 2 : 0;
        body  = dig + pre;
        total = (r.field_width < body) ? body : r.field_width;
        pad   = total - body;
        zmode = r.zero_pad && !r.left_align && !r.precision_given;
        emit  = (total < FIELD_CAP) ? total : FIELD_CAP;
        for (int unsigned i = 0; i < emit; i++)
        begin
            // position counted from the start of the prefix
            j = (r.left_align || zmode) ? i : i - pad;
            if (!r.left_align && !zmode && i < pad)
            begin
                c = CHAR_SPACE;
            end
            else if (j < pre)
            begin
                c = (j == 0) ? CHAR_ZERO : (r.upper_case ? CHAR_X_UP : CHAR_X_LO);
            end
            else if (zmode)
            begin
                // padding zeros and digits form one digit area up to the end
                c = hex_char(r.value, total - 1 - j, r.upper_case);
            end
            else if (j < body)
            begin
                c = hex_char(r.value, body - 1 - j, r.upper_case);
            end
            else
            begin
                c = CHAR_SPACE;
            end
            field_chars.push_back('{c, (i + 1 == emit), CNT_W'(emit)});
        end
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
    endtask

    // drive one field request and hold it until the transfer; sender bursts and gaps
    task automatic send_req(fmt_req_t r, ref int burst_left);
        int gap;
        @(negedge clk);
        fmt_in.valid           <= 1'b1;
        fmt_in.value           <= r.value;
        fmt_in.upper_case      <= r.upper_case;
        fmt_in.alt_form        <= r.alt_form;
        fmt_in.left_align      <= r.left_align;
        fmt_in.zero_pad        <= r.zero_pad;
        fmt_in.precision_given <= r.precision_given;
        fmt_in.precision       <= r.precision;
        fmt_in.field_width     <= r.field_width;
        do
        begin
            @(posedge clk);
        end
        while (!fmt_in.ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            // mostly short gaps, now and then long enough for the block to drain
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            @(negedge clk);
            fmt_in.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #4_000_000;
        $display("hex_field_formatter_tb: errors");
        $finish;
    end

    // receiver: runs of ready high broken by stalls of random length
    initial
    begin
        fmt_out.ready = 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 40)) @(negedge clk) fmt_out.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                // single-cycle stalls, spread over the character positions
                repeat ($urandom_range(2, 20))
                begin
                    @(negedge clk) fmt_out.ready <= 1'b0;
                    @(negedge clk) fmt_out.ready <= 1'b1;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10)) @(negedge clk) fmt_out.ready <= 1'b0;
            end
        end
    end

    // scoreboard: input transfers queue their field, output transfers are checked in order
    always @(posedge clk)
    begin
        fmt_note_t note;
        fmt_req_t  seen;
        fmt_char_t got;
        fmt_char_t want;
        if (rst_n && fmt_in.valid && fmt_in.ready)
        begin
            note = item_notes.pop_front();
            if (note.typed)
            begin
                for (int k = 0; k < note.text.len(); k++)
                begin
                    field_chars.push_back('{note.text[k], (k == note.text.len() - 1),
                                           CNT_W'(note.text.len())});
                end
            end
            else
            begin
                seen = '{fmt_in.value, fmt_in.upper_case, fmt_in.alt_form, fmt_in.left_align,
                         fmt_in.zero_pad, fmt_in.precision_given, fmt_in.precision,
                         fmt_in.field_width};
                predict_field(seen);
            end
        end
        if (rst_n && fmt_out.valid && fmt_out.ready)
        begin
            got = '{fmt_out.ch, fmt_out.last, fmt_out.field_length};
            if (field_chars.size() == 0)
            begin
                flag_mismatch("character with none pending, ch", 32'h0, 32'(got.ch));
            end
            else
            begin
                want = field_chars.pop_front();
                if (got.ch !== want.ch)
                begin
                    flag_mismatch("ch", 32'(want.ch), 32'(got.ch));
                end
                if (got.last !== want.last)
                begin
                    flag_mismatch("last", 32'(want.last), 32'(got.last));
                end
                if (got.field_length !== want.field_length)
                begin
                    flag_mismatch("field_length", 32'(want.field_length),
                                  32'(got.field_length));
                end
            end
        end
    end

    // reset, stimulus and the end of the run
    initial
    begin
        fmt_req_t req;
        int       burst;
        int       pick;
        rst_n                  = 1'b0;
        fmt_in.valid           = 1'b0;
        fmt_in.value           = '0;
        fmt_in.upper_case      = 1'b0;
        fmt_in.alt_form        = 1'b0;
        fmt_in.left_align      = 1'b0;
        fmt_in.zero_pad        = 1'b0;
        fmt_in.precision_given = 1'b0;
        fmt_in.precision       = '0;
        fmt_in.field_width     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        burst = $urandom_range(1, 30);
        foreach (directed_cases[i])
        begin
            item_notes.push_back('{directed_cases[i].typed, directed_cases[i].text});
            send_req(directed_cases[i].req, burst);
        end

        // random fields: mostly short, with the odd long or over-range one
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                req.value = '0;
            end
            else if (pick == 1)
            begin
                req.value = '1;
            end
            else
            begin
                req.value = $urandom >> (4 * $urandom_range(0, 7));
            end
            req.upper_case      = 1'($urandom_range(0, 1));
            req.alt_form        = 1'($urandom_range(0, 1));
            req.left_align      = 1'($urandom_range(0, 1));
            req.zero_pad        = 1'($urandom_range(0, 1));
            req.precision_given = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                req.precision = 6'($urandom_range(0, 10));
            end
            else if (pick < 9)
            begin
                req.precision = 6'($urandom_range(0, 63));
            end
            else
            begin
                req.precision = 6'($urandom_range(62, 63));
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                req.field_width = 7'($urandom_range(0, 16));
            end
            else if (pick < 9)
            begin
                req.field_width = 7'($urandom_range(0, 64));
            end
            else
            begin
                req.field_width = 7'($urandom_range(0, 127));
            end
            item_notes.push_back('{1'b0, ""});
            send_req(req, burst);
        end
        @(negedge clk);
        fmt_in.valid <= 1'b0;

        // drain, then give the emitter time to show any stray character
        while (field_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * FIELD_CAP) @(posedge clk);

        if (errors == 0)
        begin
            $display("hex_field_formatter_tb: clean");
        end
        else
        begin
            $display("hex_field_formatter_tb: errors");
        end
        $finish;
    end

endmodule
